// ===== src/toroidal_life_grid_step_unit_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef TOROIDAL_LIFE_GRID_STEP_UNIT_MACROS_SVH
`define TOROIDAL_LIFE_GRID_STEP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define TLG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while in reset.
`define TLG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tlg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlg_pkg;

  localparam int CMD_W = 2;
  localparam int ROW_W = 4;
  localparam int COL_W = 4;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [3:0] BIRTH_CNT = 4'd3;
  localparam logic [3:0] KEEP_CNT  = 4'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_STEP,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_val;
    logic             on_grid;
  } item_t;

endpackage

`default_nettype wire

// ===== src/tlg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tlg_in_if;
  logic                       valid;
  logic                       ready;
  logic [tlg_pkg::CMD_W-1:0]  cmd;
  logic [tlg_pkg::ROW_W-1:0]  row;
  logic [tlg_pkg::COL_W-1:0]  col;
  logic                       cell_in;

  modport source (output valid, cmd, row, col, cell_in, input ready);
  modport sink (input valid, cmd, row, col, cell_in, output ready);
endinterface

interface tlg_out_if;
  logic valid;
  logic ready;
  logic cell_out;

  modport source (output valid, cell_out, input ready);
  modport sink (input valid, cell_out, output ready);
endinterface

`default_nettype wire

// ===== src/tlg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlg_front #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  tlg_in_if.sink         in_if,
  output tlg_pkg::item_t q_item,
  output logic           q_valid,
  input  wire logic      q_ready
);

  tlg_pkg::item_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  tlg_pkg::item_t new_item;
  logic           push;
  logic           pop;

  always_comb begin
    new_item.row      = in_if.row;
    new_item.col      = in_if.col;
    new_item.cell_val = in_if.cell_in;
    new_item.on_grid  = (32'(in_if.row) < GRID_SIZE) && (32'(in_if.col) < GRID_SIZE);
    case (in_if.cmd)
      tlg_pkg::CMD_WRITE: new_item.op = tlg_pkg::OP_WRITE;
      tlg_pkg::CMD_STEP:  new_item.op = tlg_pkg::OP_STEP;
      default:            new_item.op = tlg_pkg::OP_READ;
    endcase
  end

  assign in_if.ready = (cnt_r != 2'd2);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = slot_r[rd_ptr_r];
  assign push        = in_if.valid && in_if.ready;
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/tlg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlg_back #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlg_pkg::item_t q_item,
  input  wire logic           q_valid,
  output logic                q_ready,
  tlg_out_if.source           out_if
);

  localparam int AW = $clog2(GRID_SIZE);
  localparam int CW = $clog2(GRID_SIZE + 3);
  localparam logic [CW-1:0] K_ONE   = CW'(1);
  localparam logic [CW-1:0] K_TWO   = CW'(2);
  localparam logic [CW-1:0] K_THREE = CW'(3);
  localparam logic [CW-1:0] K_RDMAX = CW'(GRID_SIZE);
  localparam logic [CW-1:0] K_LAST  = CW'(GRID_SIZE + 2);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] rd_data_r;
  logic                 rd_ok_r;
  logic [GRID_SIZE-1:0] row_ok_r;

  tlg_pkg::state_t      state_r, state_nxt;
  tlg_pkg::item_t       item_r, item_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [GRID_SIZE-1:0] up_r, up_nxt;
  logic [GRID_SIZE-1:0] mid_r, mid_nxt;
  logic [GRID_SIZE-1:0] first_r, first_nxt;
  logic                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_cell_r, out_cell_nxt;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [GRID_SIZE-1:0] wr_data;
  logic [GRID_SIZE-1:0] rd_row;
  logic [GRID_SIZE-1:0] down_row;
  logic [GRID_SIZE-1:0] new_row;
  logic [AW-1:0]        item_row;
  logic [AW-1:0]        item_col;
  logic                 slot_free;

  // A row that has never been written reads as all dead.
  assign rd_row    = rd_ok_r ? rd_data_r : '0;
  assign down_row  = (k_r == K_LAST) ? first_r : rd_row;
  assign item_row  = AW'(item_r.row);
  assign item_col  = AW'(item_r.col);
  assign slot_free = !out_valid_r || out_if.ready;

  assign out_if.valid    = out_valid_r;
  assign out_if.cell_out = out_cell_r;

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    localparam int CL = (c == 0) ? GRID_SIZE - 1 : c - 1;
    localparam int CR = (c == GRID_SIZE - 1) ? 0 : c + 1;
    logic [3:0] cnt;
    assign cnt = 4'(up_r[CL]) + 4'(up_r[c]) + 4'(up_r[CR]) + 4'(mid_r[CL]) + 4'(mid_r[CR])
               + 4'(down_row[CL]) + 4'(down_row[c]) + 4'(down_row[CR]);
    assign new_row[c] = (cnt == tlg_pkg::BIRTH_CNT) || (mid_r[c] && (cnt == tlg_pkg::KEEP_CNT));
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    k_nxt         = k_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    first_nxt     = first_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_row;
    q_ready       = 1'b0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tlg_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          item_nxt = q_item;
          res_nxt  = 1'b0;
          if (q_item.op == tlg_pkg::OP_STEP) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(GRID_SIZE - 1);
            k_nxt     = K_ONE;
            state_nxt = tlg_pkg::ST_SWEEP;
          end else begin
            rd_en     = q_item.on_grid;
            rd_addr   = AW'(q_item.row);
            state_nxt = tlg_pkg::ST_CELL;
          end
        end
      end
      tlg_pkg::ST_CELL: begin
        if (item_r.on_grid) begin
          if (item_r.op == tlg_pkg::OP_WRITE) begin
            wr_en             = 1'b1;
            wr_addr           = item_row;
            wr_data[item_col] = item_r.cell_val;
            res_nxt           = item_r.cell_val;
          end else begin
            res_nxt = rd_row[item_col];
          end
        end
        state_nxt = tlg_pkg::ST_DONE;
      end
      tlg_pkg::ST_SWEEP: begin
        // Rows are fetched one ahead of the row being rewritten; the old
        // top row is kept aside as the lower neighbour of the bottom row.
        if (k_r <= K_RDMAX) begin
          rd_en   = 1'b1;
          rd_addr = AW'(k_r - K_ONE);
        end
        if (k_r == K_ONE) begin
          up_nxt = rd_row;
        end else if (k_r == K_TWO) begin
          mid_nxt   = rd_row;
          first_nxt = rd_row;
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(k_r - K_THREE);
          wr_data = new_row;
          up_nxt  = mid_r;
          mid_nxt = down_row;
          if (item_r.on_grid && (wr_addr == item_row)) begin
            res_nxt = new_row[item_col];
          end
        end
        if (k_r == K_LAST) begin
          state_nxt = tlg_pkg::ST_DONE;
        end else begin
          k_nxt = k_r + K_ONE;
        end
      end
      tlg_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_r;
          state_nxt     = tlg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      row_ok_r    <= '0;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      if (wr_en) begin
        row_ok_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= row_ok_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    first_r    <= first_nxt;
    res_r      <= res_nxt;
    out_cell_r <= out_cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/toroidal_life_grid_step_unit.sv =====
// A read or write word goes through states CELL and DONE, a step through SWEEP and
// DONE, before its result is registered on out_if.
// The back end takes one word at a time; a two-entry queue in front holds further words.
// A step reads and rewrites the row memory one row per cycle.
// Reset: synchronous, active low; per-row valid flags make the grid read as all dead.
`timescale 1ns / 1ps
`default_nettype none

module toroidal_life_grid_step_unit #(
  parameter int GRID_SIZE = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tlg_in_if.sink    in_if,
  tlg_out_if.source out_if
);

  tlg_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  tlg_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_ready(q_ready)
  );

  tlg_back #(
    .GRID_SIZE(GRID_SIZE)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

// ===== src/tlg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "toroidal_life_grid_step_unit_macros.svh"

module tlg_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_cell_out
);

  logic [2:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  `TLG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cell_out), "stalled result word changed")
  `TLG_ASSERT_IMPLY(a_no_orphan, out_valid, pend_r != 3'd0, "result word without an accepted word")
  `TLG_ASSERT_IMPLY(a_pend_bound, 1'b1, pend_r <= 3'd4, "more words in flight than the block can hold")
  `TLG_ASSERT_IMPLY(a_full_stall, pend_r == 3'd4, !in_ready, "input accepted while every slot is taken")

endmodule

bind toroidal_life_grid_step_unit tlg_checker u_tlg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_cell_out(out_if.cell_out)
);

`default_nettype wire
